[rtl/utc_stamp_plus_duration_macros.svh]
// Assertion macros used by the uspd_back module of utc_stamp_plus_duration.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef UTC_STAMP_PLUS_DURATION_MACROS_SVH
`define UTC_STAMP_PLUS_DURATION_MACROS_SVH

// Plain property, sampled on clk, off while in reset.
`define USPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Antecedent this cycle, consequent on the next one.
`define USPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);

`endif

[rtl/uspd_pkg.sv]
// Types, codes and constant dividers for utc_stamp_plus_duration.
// No dependencies.
package uspd_pkg;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_UNIT = 2'd1;
	localparam logic [1:0] STAT_TOD  = 2'd2;
	localparam logic [1:0] STAT_YEAR = 2'd3;

	localparam logic [1:0] KIND_MIN  = 2'd0;
	localparam logic [1:0] KIND_HOUR = 2'd1;
	localparam logic [1:0] KIND_DAY  = 2'd2;
	localparam logic [1:0] KIND_WEEK = 2'd3;

	localparam logic [7:0] UNIT_MIN  = 8'h6D; // 'm'
	localparam logic [7:0] UNIT_HOUR = 8'h68; // 'h'
	localparam logic [7:0] UNIT_DAY  = 8'h64; // 'd'
	localparam logic [7:0] UNIT_WEEK = 8'h77; // 'w'

	// day index shifted by the epoch offset: 0001-01-01 and 9999-12-31
	localparam logic signed [37:0] Z_LO = 38'sd306;
	localparam logic signed [37:0] Z_HI = 38'sd3652364;

	localparam logic [21:0] ERA_LEN = 22'd146097;
	// floor(2^30/3) and floor(2^28/45)
	localparam logic [58:0] RECIP_3  = 59'd357913941;
	localparam logic [58:0] RECIP_45 = 59'd5965232;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  kind;
		logic [31:0] count;
		logic [13:0] yr;
		logic [3:0]  mo;
		logic [4:0]  dy;
		logic [4:0]  hr;
		logic [5:0]  mi;
		logic [5:0]  se;
		logic [9:0]  ms;
	} item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] hr;
		logic [5:0] mi;
		logic [5:0] se;
		logic [9:0] ms;
	} tag_t;

	// (153*mp + 2) / 5
	function automatic logic [8:0] cum_days(input logic [3:0] mp);
		logic [8:0] r;
		unique case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			4'd12:   r = 9'd367;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [5:0] div400(input logic [13:0] x);
		logic [19:0] p;
		logic [5:0]  q;
		logic [14:0] r;
		p = 20'(x) * 20'd40;
		q = p[19:14];
		r = 15'(x) - 15'(15'(q) * 15'd400);
		if (r >= 15'd400) begin
			q = q + 6'd1;
		end
		return q;
	endfunction

	// yoe / 100 for yoe below 400
	function automatic logic [1:0] div100s(input logic [8:0] x);
		logic [1:0] q;
		if (x >= 9'd300) begin
			q = 2'd3;
		end else if (x >= 9'd200) begin
			q = 2'd2;
		end else if (x >= 9'd100) begin
			q = 2'd1;
		end else begin
			q = 2'd0;
		end
		return q;
	endfunction

	function automatic logic [4:0] div60(input logic [10:0] x);
		logic [16:0] p;
		logic [4:0]  q;
		logic [10:0] r;
		p = 17'(x) * 17'd34;
		q = p[15:11];
		r = x - 11'(11'(q) * 11'd60);
		if (r >= 11'd60) begin
			q = q + 5'd1;
		end
		return q;
	endfunction

	function automatic logic [7:0] div1460(input logic [17:0] x);
		logic [25:0] p;
		logic [7:0]  q;
		logic [19:0] r;
		p = 26'(x) * 26'd179;
		q = p[25:18];
		r = 20'(x) - 20'(20'(q) * 20'd1460);
		if (r >= 20'd1460) begin
			q = q + 8'd1;
		end
		return q;
	endfunction

	function automatic logic [2:0] div36524(input logic [17:0] x);
		logic [2:0] q;
		if (x >= 18'd146096) begin
			q = 3'd4;
		end else if (x >= 18'd109572) begin
			q = 3'd3;
		end else if (x >= 18'd73048) begin
			q = 3'd2;
		end else if (x >= 18'd36524) begin
			q = 3'd1;
		end else begin
			q = 3'd0;
		end
		return q;
	endfunction

	function automatic logic [8:0] div365(input logic [17:0] x);
		logic [27:0] p;
		logic [9:0]  q;
		logic [19:0] r;
		p = 28'(x) * 28'd718;
		q = p[27:18];
		r = 20'(x) - 20'(20'(q) * 20'd365);
		if (r >= 20'd365) begin
			q = q + 10'd1;
		end
		return q[8:0];
	endfunction

	function automatic logic [3:0] div153(input logic [10:0] x);
		logic [14:0] p;
		logic [3:0]  q;
		logic [11:0] r;
		p = 15'(x) * 15'd13;
		q = p[14:11];
		r = 12'(x) - 12'(12'(q) * 12'd153);
		if (r >= 12'd153) begin
			q = q + 4'd1;
		end
		return q;
	endfunction

endpackage

[rtl/uspd_front.sv]
// Front end: input register, unit decode and error classification.
// Depends on uspd_pkg.
module uspd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [31:0]         ttl_count,
	input  logic [7:0]          unit_code,
	input  logic [13:0]         now_year,
	input  logic [3:0]          now_month,
	input  logic [4:0]          now_day,
	input  logic [6:0]          now_hour,
	input  logic [6:0]          now_minute,
	input  logic [6:0]          now_second,
	input  logic [9:0]          now_millis,
	input  logic                q_full,
	output logic                push,
	output uspd_pkg::item_t     push_item
);

	logic            fr_valid_q;
	uspd_pkg::item_t fr_item_q;
	uspd_pkg::item_t cls;
	logic            accept;
	logic            unit_ok;

	assign in_stall  = fr_valid_q && q_full;
	assign accept    = in_valid && !in_stall;
	assign push      = fr_valid_q && !q_full;
	assign push_item = fr_item_q;

	always_comb begin
		unit_ok  = 1'b1;
		cls.kind = uspd_pkg::KIND_MIN;
		unique case (unit_code)
			uspd_pkg::UNIT_MIN:  cls.kind = uspd_pkg::KIND_MIN;
			uspd_pkg::UNIT_HOUR: cls.kind = uspd_pkg::KIND_HOUR;
			uspd_pkg::UNIT_DAY:  cls.kind = uspd_pkg::KIND_DAY;
			uspd_pkg::UNIT_WEEK: cls.kind = uspd_pkg::KIND_WEEK;
			default:             unit_ok  = 1'b0;
		endcase
		// unit first, then time of day
		if (!unit_ok || ttl_count == 32'd0) begin
			cls.status = uspd_pkg::STAT_UNIT;
		end else if (now_hour > 7'd23 || now_minute > 7'd59 || now_second > 7'd59
				|| now_millis > 10'd999) begin
			cls.status = uspd_pkg::STAT_TOD;
		end else begin
			cls.status = uspd_pkg::STAT_OK;
		end
		cls.count = ttl_count;
		cls.yr    = now_year;
		cls.mo    = now_month;
		cls.dy    = now_day;
		cls.hr    = now_hour[4:0];
		cls.mi    = now_minute[5:0];
		cls.se    = now_second[5:0];
		cls.ms    = now_millis;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_valid_q <= 1'b0;
		end else begin
			fr_valid_q <= accept || (fr_valid_q && q_full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fr_item_q <= cls;
		end
	end

endmodule

[rtl/uspd_fifo.sv]
// Short queue between front and back ends.
// Depends on uspd_pkg.
module uspd_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  uspd_pkg::item_t push_item,
	output logic            full,
	output logic            pop_valid,
	input  logic            pop,
	output uspd_pkg::item_t pop_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	uspd_pkg::item_t mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_pop;

	assign full      = (cnt_q == CW'(DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_item  = mem_q[rd_q];
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

endmodule

[rtl/uspd_back.sv]
// Back end: 11-stage pipeline, civil date to day count, duration add, and back.
// Depends on uspd_pkg and utc_stamp_plus_duration_macros.svh.
`include "utc_stamp_plus_duration_macros.svh"
module uspd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  uspd_pkg::item_t item,
	output logic            take,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [13:0]     exp_year,
	output logic [3:0]      exp_month,
	output logic [4:0]      exp_day,
	output logic [4:0]      exp_hour,
	output logic [5:0]      exp_minute,
	output logic [5:0]      exp_second,
	output logic [9:0]      exp_millis,
	output logic [1:0]      status
);

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;

	assign adv  = !(v_s11 && out_stall);
	assign take = item_valid && adv;

	// stage 1: forward era split, time-of-day folding
	uspd_pkg::tag_t     tag_s1;
	logic [1:0]         kind_s1;
	logic [31:0]        count_s1;
	logic signed [6:0]  era_s1;
	logic [8:0]         yoe_s1;
	logic signed [11:0] doy_s1;
	logic [32:0]        t_s1;

	logic signed [15:0] y1_c;
	logic [5:0]         q400_c;
	logic [13:0]        yrem_c;
	logic signed [6:0]  era1_c;
	logic [8:0]         yoe1_c;
	logic [3:0]         mp1_c;
	logic [32:0]        t1_c;

	always_comb begin
		y1_c   = $signed({2'b0, item.yr}) - ((item.mo <= 4'd2) ? 16'sd1 : 16'sd0);
		q400_c = uspd_pkg::div400(y1_c[13:0]);
		yrem_c = y1_c[13:0] - 14'(14'(q400_c) * 14'd400);
		if (y1_c[15]) begin
			era1_c = -7'sd1;
			yoe1_c = 9'd399;
		end else begin
			era1_c = $signed({1'b0, q400_c});
			yoe1_c = yrem_c[8:0];
		end
		mp1_c = (item.mo > 4'd2) ? item.mo - 4'd3 : item.mo + 4'd9;
		unique case (item.kind)
			uspd_pkg::KIND_HOUR: t1_c = 33'(item.count) + 33'(item.hr);
			uspd_pkg::KIND_MIN:  t1_c = 33'(item.count)
				+ 33'(11'(11'(item.hr) * 11'd60) + 11'(item.mi));
			uspd_pkg::KIND_DAY:  t1_c = 33'(item.count);
			uspd_pkg::KIND_WEEK: t1_c = 33'(item.count);
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1   <= '{status: item.status, hr: item.hr, mi: item.mi,
				se: item.se, ms: item.ms};
			kind_s1  <= item.kind;
			count_s1 <= item.count;
			era_s1   <= era1_c;
			yoe_s1   <= yoe1_c;
			doy_s1   <= $signed({3'b0, uspd_pkg::cum_days(mp1_c)})
				+ $signed({7'b0, item.dy}) - 12'sd1;
			t_s1     <= t1_c;
		end
	end

	// stage 2: day of era, era offset, reciprocal product for the time carry
	uspd_pkg::tag_t     tag_s2;
	logic [1:0]         kind_s2;
	logic [31:0]        count_s2;
	logic signed [23:0] erac_s2;
	logic signed [18:0] doe_s2;
	logic [29:0]        x_s2;
	logic [58:0]        p_s2;
	logic [4:0]         lo_s2;

	logic [17:0] base2_c;
	logic [29:0] x2_c;

	always_comb begin
		base2_c = 18'(18'(yoe_s1) * 18'd365) + 18'(yoe_s1 >> 2)
			- 18'(uspd_pkg::div100s(yoe_s1));
		x2_c = (kind_s1 == uspd_pkg::KIND_HOUR) ? t_s1[32:3] : {2'b0, t_s1[32:5]};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s2   <= tag_s1;
			kind_s2  <= kind_s1;
			count_s2 <= count_s1;
			erac_s2  <= 24'(era_s1) * 24'sd146097;
			doe_s2   <= $signed({1'b0, base2_c}) + 19'(doy_s1);
			x_s2     <= x2_c;
			p_s2     <= 59'(x2_c) * ((kind_s1 == uspd_pkg::KIND_HOUR)
				? uspd_pkg::RECIP_3 : uspd_pkg::RECIP_45);
			lo_s2    <= t_s1[4:0];
		end
	end

	// stage 3: shifted day index, estimated quotient
	uspd_pkg::tag_t     tag_s3;
	logic [1:0]         kind_s3;
	logic [31:0]        count_s3;
	logic signed [24:0] z0_s3;
	logic [29:0]        x_s3;
	logic [29:0]        q0_s3;
	logic [4:0]         lo_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s3   <= tag_s2;
			kind_s3  <= kind_s2;
			count_s3 <= count_s2;
			z0_s3    <= 25'(erac_s2) + 25'(doe_s2);
			x_s3     <= x_s2;
			q0_s3    <= (kind_s2 == uspd_pkg::KIND_HOUR) ? 30'(p_s2[58:30]) : p_s2[57:28];
			lo_s3    <= lo_s2;
		end
	end

	// stage 4: quotient correction
	uspd_pkg::tag_t     tag_s4;
	logic [1:0]         kind_s4;
	logic [31:0]        count_s4;
	logic signed [24:0] z0_s4;
	logic [29:0]        q_s4;
	logic [5:0]         r_s4;
	logic [4:0]         lo_s4;

	logic [5:0]  c4_c;
	logic [29:0] rr4_c;
	logic [29:0] q4_c;

	always_comb begin
		c4_c  = (kind_s3 == uspd_pkg::KIND_HOUR) ? 6'd3 : 6'd45;
		rr4_c = x_s3 - 30'(q0_s3 * 30'(c4_c));
		q4_c  = q0_s3;
		if (rr4_c >= 30'(c4_c)) begin
			q4_c  = q0_s3 + 30'd1;
			rr4_c = rr4_c - 30'(c4_c);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s4   <= tag_s3;
			kind_s4  <= kind_s3;
			count_s4 <= count_s3;
			z0_s4    <= z0_s3;
			q_s4     <= q4_c;
			r_s4     <= rr4_c[5:0];
			lo_s4    <= lo_s3;
		end
	end

	// stage 5: new time of day, add whole days
	uspd_pkg::tag_t     tag_s5;
	logic signed [37:0] zr_s5;

	logic [34:0]    dadd_c;
	logic [10:0]    rmin_c;
	logic [4:0]     hr60_c;
	uspd_pkg::tag_t tag5_c;

	always_comb begin
		tag5_c = tag_s4;
		rmin_c = {r_s4, lo_s4};
		hr60_c = uspd_pkg::div60(rmin_c);
		unique case (kind_s4)
			uspd_pkg::KIND_HOUR: begin
				dadd_c    = 35'(q_s4);
				tag5_c.hr = {r_s4[1:0], lo_s4[2:0]};
			end
			uspd_pkg::KIND_MIN: begin
				dadd_c    = 35'(q_s4);
				tag5_c.hr = hr60_c;
				tag5_c.mi = 6'(rmin_c - 11'(11'(hr60_c) * 11'd60));
			end
			uspd_pkg::KIND_DAY:  dadd_c = 35'(count_s4);
			uspd_pkg::KIND_WEEK: dadd_c = {count_s4, 3'b0} - 35'(count_s4);
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s5 <= tag5_c;
			zr_s5  <= 38'(z0_s4) + $signed({3'b0, dadd_c});
		end
	end

	// stage 6: year range check, era estimate
	uspd_pkg::tag_t tag_s6;
	logic [21:0]    z_s6;
	logic [4:0]     eq_s6;

	uspd_pkg::tag_t tag6_c;
	logic [26:0]    p6_c;

	always_comb begin
		tag6_c = tag_s5;
		if (tag_s5.status == uspd_pkg::STAT_OK
				&& (zr_s5 < uspd_pkg::Z_LO || zr_s5 > uspd_pkg::Z_HI)) begin
			tag6_c.status = uspd_pkg::STAT_YEAR;
		end
		p6_c = 27'(zr_s5[21:0]) * 27'd28;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s6 <= tag6_c;
			z_s6   <= zr_s5[21:0];
			eq_s6  <= p6_c[26:22];
		end
	end

	// stage 7: era and day of era
	uspd_pkg::tag_t tag_s7;
	logic [4:0]     era_s7;
	logic [17:0]    doe_s7;

	logic [21:0] rr7_c;
	logic [4:0]  era7_c;

	always_comb begin
		rr7_c  = z_s6 - 22'(22'(eq_s6) * uspd_pkg::ERA_LEN);
		era7_c = eq_s6;
		if (rr7_c >= uspd_pkg::ERA_LEN) begin
			era7_c = eq_s6 + 5'd1;
			rr7_c  = rr7_c - uspd_pkg::ERA_LEN;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s7 <= tag_s6;
			era_s7 <= era7_c;
			doe_s7 <= rr7_c[17:0];
		end
	end

	// stage 8: leap-corrected day count
	uspd_pkg::tag_t tag_s8;
	logic [4:0]     era_s8;
	logic [17:0]    doe_s8;
	logic [17:0]    n_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s8 <= tag_s7;
			era_s8 <= era_s7;
			doe_s8 <= doe_s7;
			n_s8   <= doe_s7 - 18'(uspd_pkg::div1460(doe_s7))
				+ 18'(uspd_pkg::div36524(doe_s7))
				- ((doe_s7 == 18'd146096) ? 18'd1 : 18'd0);
		end
	end

	// stage 9: year of era
	uspd_pkg::tag_t tag_s9;
	logic [4:0]     era_s9;
	logic [17:0]    doe_s9;
	logic [8:0]     yoe_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s9 <= tag_s8;
			era_s9 <= era_s8;
			doe_s9 <= doe_s8;
			yoe_s9 <= uspd_pkg::div365(n_s8);
		end
	end

	// stage 10: day of year
	uspd_pkg::tag_t tag_s10;
	logic [4:0]     era_s10;
	logic [8:0]     yoe_s10;
	logic [8:0]     doy_s10;

	logic [17:0] yd10_c;
	logic [17:0] doy10_c;

	always_comb begin
		yd10_c = 18'(18'(yoe_s9) * 18'd365) + 18'(yoe_s9 >> 2)
			- 18'(uspd_pkg::div100s(yoe_s9));
		doy10_c = doe_s9 - yd10_c;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s10 <= tag_s9;
			era_s10 <= era_s9;
			yoe_s10 <= yoe_s9;
			doy_s10 <= doy10_c[8:0];
		end
	end

	// stage 11: month, day, year; output register
	logic [13:0] year_s11;
	logic [3:0]  month_s11;
	logic [4:0]  day_s11;
	logic [4:0]  hour_s11;
	logic [5:0]  minute_s11;
	logic [5:0]  second_s11;
	logic [9:0]  millis_s11;
	logic [1:0]  status_s11;

	logic [3:0]  mp11_c;
	logic [3:0]  m11_c;
	logic [8:0]  d11_c;
	logic [13:0] y11_c;
	logic        ok11_c;

	always_comb begin
		mp11_c = uspd_pkg::div153(11'(11'(doy_s10) * 11'd5) + 11'd2);
		d11_c  = doy_s10 - uspd_pkg::cum_days(mp11_c) + 9'd1;
		m11_c  = (mp11_c < 4'd10) ? mp11_c + 4'd3 : mp11_c - 4'd9;
		y11_c  = 14'(yoe_s10) + 14'(14'(era_s10) * 14'd400)
			+ ((m11_c <= 4'd2) ? 14'd1 : 14'd0);
		ok11_c = (tag_s10.status == uspd_pkg::STAT_OK);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s11 <= tag_s10.status;
			year_s11   <= ok11_c ? y11_c : 14'd0;
			month_s11  <= ok11_c ? m11_c : 4'd0;
			day_s11    <= ok11_c ? d11_c[4:0] : 5'd0;
			hour_s11   <= ok11_c ? tag_s10.hr : 5'd0;
			minute_s11 <= ok11_c ? tag_s10.mi : 6'd0;
			second_s11 <= ok11_c ? tag_s10.se : 6'd0;
			millis_s11 <= ok11_c ? tag_s10.ms : 10'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (adv) begin
			v_s1  <= take;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	assign out_valid  = v_s11;
	assign exp_year   = year_s11;
	assign exp_month  = month_s11;
	assign exp_day    = day_s11;
	assign exp_hour   = hour_s11;
	assign exp_minute = minute_s11;
	assign exp_second = second_s11;
	assign exp_millis = millis_s11;
	assign status     = status_s11;

	`USPD_ASSERT(a_err_zeroes, (v_s11 && status_s11 != uspd_pkg::STAT_OK) |-> (year_s11 == 14'd0 && month_s11 == 4'd0 && day_s11 == 5'd0 && millis_s11 == 10'd0), "error result carries nonzero fields")
	`USPD_ASSERT(a_ok_in_range, (v_s11 && status_s11 == uspd_pkg::STAT_OK) |-> (year_s11 >= 14'd1 && year_s11 <= 14'd9999 && month_s11 >= 4'd1 && month_s11 <= 4'd12 && day_s11 >= 5'd1 && hour_s11 <= 5'd23 && minute_s11 <= 6'd59), "ok result out of civil range")
	`USPD_ASSERT_NEXT(a_freeze, (v_s10 && v_s11 && out_stall), (v_s10 && v_s11), "pipeline lost a transaction while stalled")

endmodule

[rtl/utc_stamp_plus_duration.sv]
// Top level of utc_stamp_plus_duration: front end, queue, back-end pipeline.
// Depends on uspd_pkg, uspd_front, uspd_fifo and uspd_back.
//
// Usage:
//   Input channel in_valid/in_stall carries one transaction: a start UTC
//   time (now_*) and a duration (ttl_count units of unit_code 'm','h','d','w').
//   Output channel out_valid/out_stall returns one result transaction for
//   every input: the expiry time (exp_*) and a status code
//   (0 ok, 1 bad unit or zero count, 2 bad time of day, 3 year outside
//   1..9999). On any error every exp_* field is zero.
//   A transaction moves when valid is high and stall is low at a clock edge.
// Path: from input accept to out_valid a transaction passes the front
//   register, the queue and then the back-end stages, of which the last
//   is the output register.
// Throughput: one transaction per cycle while out_stall is low; the back end
//   is a fully pipelined constant-divider datapath with no loop.
// Stalls: while out_valid and out_stall are both high, the whole back end
//   freezes and the queue (QUEUE_DEPTH entries) fills; once it and the front
//   register are full, in_stall rises. Results are never dropped or reordered.
// Reset: arst_n (async, active low) empties the pipeline, queue and front
//   register; no clearing pass, items are accepted as soon as reset is released.
module utc_stamp_plus_duration #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] ttl_count,
	input  logic [7:0]  unit_code,
	input  logic [13:0] now_year,
	input  logic [3:0]  now_month,
	input  logic [4:0]  now_day,
	input  logic [6:0]  now_hour,
	input  logic [6:0]  now_minute,
	input  logic [6:0]  now_second,
	input  logic [9:0]  now_millis,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [13:0] exp_year,
	output logic [3:0]  exp_month,
	output logic [4:0]  exp_day,
	output logic [4:0]  exp_hour,
	output logic [5:0]  exp_minute,
	output logic [5:0]  exp_second,
	output logic [9:0]  exp_millis,
	output logic [1:0]  status
);

	// front -> queue
	logic            push;
	uspd_pkg::item_t push_item;
	logic            q_full;

	// queue -> back end
	logic            q_valid;
	uspd_pkg::item_t q_item;
	logic            q_take;

	uspd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.ttl_count  (ttl_count),
		.unit_code  (unit_code),
		.now_year   (now_year),
		.now_month  (now_month),
		.now_day    (now_day),
		.now_hour   (now_hour),
		.now_minute (now_minute),
		.now_second (now_second),
		.now_millis (now_millis),
		.q_full     (q_full),
		.push       (push),
		.push_item  (push_item)
	);

	uspd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop       (q_take),
		.pop_item  (q_item)
	);

	// Back end converts, adds the duration, converts back and range-checks.
	uspd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item       (q_item),
		.take       (q_take),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.exp_year   (exp_year),
		.exp_month  (exp_month),
		.exp_day    (exp_day),
		.exp_hour   (exp_hour),
		.exp_minute (exp_minute),
		.exp_second (exp_second),
		.exp_millis (exp_millis),
		.status     (status)
	);

endmodule

[verif/utc_stamp_plus_duration_test.sv]
// Self-checking testbench for utc_stamp_plus_duration: UTC stamp plus TTL.
// Depends on uspd_pkg (status and unit codes) and the utc_stamp_plus_duration RTL.
`timescale 1ns / 1ps

module utc_stamp_plus_duration_test;

	localparam longint ERA_DAYS   = 146097;
	localparam longint EPOCH_OFS  = 719468;
	localparam longint DAY_SECS   = 86400;
	localparam longint LAST_YEAR  = 9999;

	typedef struct {
		logic [31:0] count;
		logic [7:0]  unit;
		logic [13:0] yr;
		logic [3:0]  mo;
		logic [4:0]  dy;
		logic [6:0]  hr;
		logic [6:0]  mi;
		logic [6:0]  se;
		logic [9:0]  ms;
	} stamp_t;

	typedef struct {
		logic [13:0] yr;
		logic [3:0]  mo;
		logic [4:0]  dy;
		logic [4:0]  hr;
		logic [5:0]  mi;
		logic [5:0]  se;
		logic [9:0]  ms;
		logic [1:0]  st;
	} expiry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] ttl_count = '0;
	logic [7:0]  unit_code = '0;
	logic [13:0] now_year = '0;
	logic [3:0]  now_month = '0;
	logic [4:0]  now_day = '0;
	logic [6:0]  now_hour = '0;
	logic [6:0]  now_minute = '0;
	logic [6:0]  now_second = '0;
	logic [9:0]  now_millis = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [13:0] exp_year;
	logic [3:0]  exp_month;
	logic [4:0]  exp_day;
	logic [4:0]  exp_hour;
	logic [5:0]  exp_minute;
	logic [5:0]  exp_second;
	logic [9:0]  exp_millis;
	logic [1:0]  status;

	expiry_t expiry_q[$];
	int mismatches = 0;
	int send_idle_pct = 0;   // sender gap probability, percent
	int stall_pct = 0;       // receiver stall probability, percent
	int hold_cycles = 0;     // forced receiver hold-off, counted down

	utc_stamp_plus_duration DUT (.*);

	always #5 clk = ~clk;

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Predictor: civil -> day number -> add TTL -> civil
	// ---------------------------------------------------------------------
	function automatic longint fdiv(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0) begin
			q = q - 1;
		end
		return q;
	endfunction

	function automatic longint day_number(longint y, longint m, longint d);
		longint era, yoe, doy, doe, mp;
		if (m <= 2) begin
			y = y - 1;
		end
		era = fdiv(y, 400);
		yoe = y - era * 400;
		mp = (m > 2) ? (m - 3) : (m + 9);
		doy = (153 * mp + 2) / 5 + (d - 1);
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		return era * ERA_DAYS + doe - EPOCH_OFS;
	endfunction

	function automatic expiry_t predict_expiry(stamp_t s);
		expiry_t r;
		longint mul, secs, days, rem, z, era, doe, yoe, doy, mp, y, m, d;
		r = '{default: '0};
		case (s.unit)
			uspd_pkg::UNIT_MIN:  mul = 60;
			uspd_pkg::UNIT_HOUR: mul = 3600;
			uspd_pkg::UNIT_DAY:  mul = DAY_SECS;
			uspd_pkg::UNIT_WEEK: mul = 7 * DAY_SECS;
			default:             mul = 0;
		endcase
		if (mul == 0 || s.count == 0) begin
			r.st = uspd_pkg::STAT_UNIT;
			return r;
		end
		if (s.hr > 23 || s.mi > 59 || s.se > 59 || s.ms > 999) begin
			r.st = uspd_pkg::STAT_TOD;
			return r;
		end
		secs = day_number(longint'(s.yr), longint'(s.mo), longint'(s.dy)) * DAY_SECS
			+ longint'(s.hr) * 3600 + longint'(s.mi) * 60 + longint'(s.se);
		secs = secs + longint'(s.count) * mul;
		days = fdiv(secs, DAY_SECS);
		rem = secs - days * DAY_SECS;
		z = days + EPOCH_OFS;
		era = fdiv(z, ERA_DAYS);
		doe = z - era * ERA_DAYS;
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp = (5 * doy + 2) / 153;
		d = doy - (153 * mp + 2) / 5 + 1;
		m = (mp < 10) ? (mp + 3) : (mp - 9);
		y = yoe + era * 400 + ((m <= 2) ? 1 : 0);
		if (y < 1 || y > LAST_YEAR) begin
			r.st = uspd_pkg::STAT_YEAR;
			return r;
		end
		r.yr = y[13:0];
		r.mo = m[3:0];
		r.dy = d[4:0];
		r.hr = 5'(rem / 3600);
		r.mi = 6'((rem / 60) % 60);
		r.se = 6'(rem % 60);
		r.ms = s.ms;
		r.st = uspd_pkg::STAT_OK;
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Receiver: random stall plus an optional long hold-off
	// ---------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Result checker: every accepted result against the oldest expectation
	always @(posedge clk) begin
		expiry_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expiry_q.size() == 0) begin
				$error("result transaction with no expectation pending");
				mismatches++;
			end else begin
				e = expiry_q.pop_front();
				if (status !== e.st) begin
					$error("status exp %0d got %0d", e.st, status); mismatches++;
				end
				if (exp_year !== e.yr) begin
					$error("exp_year exp %0d got %0d", e.yr, exp_year); mismatches++;
				end
				if (exp_month !== e.mo) begin
					$error("exp_month exp %0d got %0d", e.mo, exp_month); mismatches++;
				end
				if (exp_day !== e.dy) begin
					$error("exp_day exp %0d got %0d", e.dy, exp_day); mismatches++;
				end
				if (exp_hour !== e.hr) begin
					$error("exp_hour exp %0d got %0d", e.hr, exp_hour); mismatches++;
				end
				if (exp_minute !== e.mi) begin
					$error("exp_minute exp %0d got %0d", e.mi, exp_minute); mismatches++;
				end
				if (exp_second !== e.se) begin
					$error("exp_second exp %0d got %0d", e.se, exp_second); mismatches++;
				end
				if (exp_millis !== e.ms) begin
					$error("exp_millis exp %0d got %0d", e.ms, exp_millis); mismatches++;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Sender: one transaction, with optional idle gap in front.
	// Called right after a falling edge; returns right after one.
	// ---------------------------------------------------------------------
	task automatic send_stamp(stamp_t s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid   = 1'b1;
		ttl_count  = s.count;
		unit_code  = s.unit;
		now_year   = s.yr;
		now_month  = s.mo;
		now_day    = s.dy;
		now_hour   = s.hr;
		now_minute = s.mi;
		now_second = s.se;
		now_millis = s.ms;
		do begin
			@(posedge clk);
		end while (in_stall);
		expiry_q.push_back(predict_expiry(s));
		@(negedge clk);
	endtask

	task automatic go_idle();
		in_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (expiry_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	function automatic stamp_t mk(logic [31:0] c, logic [7:0] u, int y, int mo, int d,
		int h, int mi, int se, int ms);
		stamp_t s;
		s.count = c; s.unit = u; s.yr = 14'(y); s.mo = 4'(mo); s.dy = 5'(d);
		s.hr = 7'(h); s.mi = 7'(mi); s.se = 7'(se); s.ms = 10'(ms);
		return s;
	endfunction

	// Mostly well-formed stamps; the rest spans every field's full width.
	function automatic stamp_t rand_stamp();
		stamp_t s;
		logic [7:0] units[4] = '{uspd_pkg::UNIT_MIN, uspd_pkg::UNIT_HOUR,
			uspd_pkg::UNIT_DAY, uspd_pkg::UNIT_WEEK};
		if ($urandom_range(99) < 15) begin
			s.count = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
			s.unit = ($urandom_range(1) == 0) ? 8'($urandom) : units[$urandom_range(3)];
			s.yr = 14'($urandom_range(0, 16383));
			s.mo = 4'($urandom_range(0, 15));
			s.dy = 5'($urandom_range(0, 31));
			s.hr = 7'($urandom_range(0, 127));
			s.mi = 7'($urandom_range(0, 127));
			s.se = 7'($urandom_range(0, 127));
			s.ms = 10'($urandom_range(0, 1023));
		end else begin
			case ($urandom_range(3))
				0: s.count = $urandom_range(1, 100);
				1: s.count = $urandom_range(1, 100000);
				2: s.count = $urandom_range(1, 20000000);
				default: s.count = $urandom;
			endcase
			s.unit = units[$urandom_range(3)];
			s.yr = ($urandom_range(9) == 0) ? 14'($urandom_range(9990, 9999))
				: 14'($urandom_range(1, 9999));
			s.mo = 4'($urandom_range(1, 12));
			s.dy = 5'($urandom_range(1, 31));
			s.hr = 7'($urandom_range(0, 23));
			s.mi = 7'($urandom_range(0, 59));
			s.se = 7'($urandom_range(0, 59));
			s.ms = 10'($urandom_range(0, 999));
		end
		return s;
	endfunction

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------
	task automatic test_directed();
		send_idle_pct = 0; stall_pct = 0;
		// leap day rollover, 400-year leap, century non-leap
		send_stamp(mk(1, uspd_pkg::UNIT_MIN, 2024, 2, 29, 23, 59, 59, 999));
		send_stamp(mk(1, uspd_pkg::UNIT_DAY, 2000, 2, 28, 0, 0, 0, 0));
		send_stamp(mk(1, uspd_pkg::UNIT_DAY, 1900, 2, 28, 12, 0, 0, 5));
		send_stamp(mk(1, uspd_pkg::UNIT_HOUR, 1970, 1, 1, 0, 0, 0, 0));
		send_stamp(mk(1, uspd_pkg::UNIT_WEEK, 1, 1, 1, 0, 0, 0, 1));
		// max count
		send_stamp(mk(32'hFFFF_FFFF, uspd_pkg::UNIT_MIN, 1, 1, 1, 0, 0, 0, 7));
		send_stamp(mk(32'hFFFF_FFFF, uspd_pkg::UNIT_WEEK, 2000, 6, 15, 1, 2, 3, 4));
		// start in the last minute of 9999; both end past year 9999
		send_stamp(mk(1, uspd_pkg::UNIT_MIN, 9999, 12, 31, 23, 59, 0, 0));
		send_stamp(mk(1, uspd_pkg::UNIT_MIN, 9999, 12, 31, 23, 59, 59, 0));
		// year 0: one minute later stays below 1, one week later reaches year 1
		send_stamp(mk(1, uspd_pkg::UNIT_MIN, 0, 1, 1, 0, 0, 0, 0));
		send_stamp(mk(1, uspd_pkg::UNIT_WEEK, 0, 12, 31, 0, 0, 0, 0));
		// bad unit codes
		send_stamp(mk(1, 8'd0, 2020, 5, 5, 5, 5, 5, 5));
		send_stamp(mk(1, 8'hFF, 2020, 5, 5, 5, 5, 5, 5));
		// zero count, and unit checked before time of day
		send_stamp(mk(0, uspd_pkg::UNIT_DAY, 2020, 5, 5, 5, 5, 5, 5));
		send_stamp(mk(0, uspd_pkg::UNIT_DAY, 2020, 5, 5, 99, 5, 5, 5));
		// time of day limits
		send_stamp(mk(1, uspd_pkg::UNIT_DAY, 2020, 5, 5, 24, 0, 0, 0));
		send_stamp(mk(1, uspd_pkg::UNIT_DAY, 2020, 5, 5, 0, 60, 0, 0));
		send_stamp(mk(1, uspd_pkg::UNIT_DAY, 2020, 5, 5, 0, 0, 60, 0));
		send_stamp(mk(1, uspd_pkg::UNIT_DAY, 2020, 5, 5, 127, 127, 127, 1023));
		send_stamp(mk(1, uspd_pkg::UNIT_DAY, 2020, 5, 5, 0, 0, 0, 1000));
		// month 0 and 15, day 0, all-ones year
		send_stamp(mk(1, uspd_pkg::UNIT_HOUR, 2021, 0, 15, 0, 0, 0, 0));
		send_stamp(mk(1, uspd_pkg::UNIT_HOUR, 2021, 15, 31, 0, 0, 0, 0));
		send_stamp(mk(1, uspd_pkg::UNIT_HOUR, 2021, 3, 0, 0, 0, 0, 0));
		send_stamp(mk(1, uspd_pkg::UNIT_HOUR, 16383, 15, 31, 23, 59, 59, 999));
		go_idle();
	endtask

	task automatic test_random(int n, int idle, int stall);
		send_idle_pct = idle; stall_pct = stall;
		repeat (n) send_stamp(rand_stamp());
		go_idle();
	endtask

	// Receiver holds off long enough to fill the queue and stall the input.
	task automatic test_backpressure();
		send_idle_pct = 0; stall_pct = 0;
		hold_cycles = 60;
		repeat (40) send_stamp(rand_stamp());
		go_idle();
	endtask

	// Sender pauses until every pending result has come back.
	task automatic test_drain_pause();
		send_idle_pct = 0; stall_pct = 30;
		repeat (10) send_stamp(rand_stamp());
		go_idle();
		wait_drained();
		repeat (10) send_stamp(rand_stamp());
		go_idle();
	endtask

	initial begin
		int guard;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(100, 0, 0);
		test_random(80, 55, 0);
		test_random(80, 0, 55);
		test_random(80, 19, 19);
		test_backpressure();
		test_drain_pause();
		test_random(40, 0, 0);
		stall_pct = 0;
		guard = 0;
		while (expiry_q.size() != 0 && guard < 5000) begin
			@(negedge clk);
			guard++;
		end
		repeat (20) @(negedge clk);
		if (expiry_q.size() != 0) begin
			$error("%0d expected results never arrived", expiry_q.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
